/* rtl/cc20_pkg.sv */
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and the half-quarter-round helper for the ChaCha20 core.
// ----------------------------------------------------------------------------
package cc20_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
    } t_quad;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic restart;
        logic start_block;
        logic round_step;
        logic odd_half;
        logic diag;
        logic final_add;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pos_zero;
        logic out_free;
    } t_status;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_ADDR_W-1:0] REG_KEY_01   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_23   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_45   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_67   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_NONCE_07 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_NONCE_8B = 3'd5;

    localparam t_word SIGMA0 = 32'h6170_7865;
    localparam t_word SIGMA1 = 32'h3320_646e;
    localparam t_word SIGMA2 = 32'h7962_2d32;
    localparam t_word SIGMA3 = 32'h6b20_6574;

    // 10 double rounds, each column and diagonal round split into two halves
    localparam int ROUND_STEPS = 40;
    localparam int STEP_W      = 6;

    // Half a quarter round: two add-xor-rotate lines
    function automatic t_quad qr_half(t_word a, t_word b, t_word c, t_word d,
                                      logic odd_half);
        t_word a1;
        t_word dx;
        t_word d1;
        t_word c1;
        t_word bx;
        t_word b1;
        t_quad q;
        a1 = a + b;
        dx = d ^ a1;
        d1 = odd_half ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
        c1 = c + d1;
        bx = b ^ c1;
        b1 = odd_half ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
        q.a = a1;
        q.b = b1;
        q.c = c1;
        q.d = d1;
        return q;
    endfunction

endpackage

/* rtl/cc20_ctrl.sv */
// ----------------------------------------------------------------------------
// cc20_ctrl
// Sequencer: accepts words, runs the round steps of a block, emits results.
// ----------------------------------------------------------------------------
module cc20_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_kind,
    input  cc20_pkg::t_status i_status,
    output logic             o_in_ready,
    output cc20_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam logic [cc20_pkg::STEP_W-1:0] LAST_STEP =
        cc20_pkg::STEP_W'(cc20_pkg::ROUND_STEPS - 1);

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic [cc20_pkg::STEP_W-1:0] r_step;
    logic [cc20_pkg::STEP_W-1:0] n_step;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.odd_half = r_step[0];
        o_cmd.diag     = r_step[1];
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_kind == cc20_pkg::KIND_RESTART) begin
                        o_cmd.restart = 1'b1;
                    end else begin
                        o_cmd.load_item = 1'b1;
                        if (i_status.pos_zero) begin
                            o_cmd.start_block = 1'b1;
                            n_step  = '0;
                            n_state = ST_ROUND;
                        end else begin
                            n_state = ST_EMIT;
                        end
                    end
                end
            end
            ST_ROUND: begin
                o_cmd.round_step = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                o_cmd.final_add = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

/* rtl/cc20_datapath.sv */
// ----------------------------------------------------------------------------
// cc20_datapath
// Config registers, block counter, round state and keystream, output register.
// ----------------------------------------------------------------------------
module cc20_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cc20_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [cc20_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_end_of_call,
    input  logic                              i_out_ready,
    input  cc20_pkg::t_cmd                    i_cmd,
    output cc20_pkg::t_status                 o_status,
    output logic                              o_out_valid,
    output logic [7:0]                        o_out_byte,
    output logic                              o_last_of_call
);

    logic [63:0]           r_key [4];
    logic [63:0]           r_nonce_lo;
    logic [31:0]           r_nonce_hi;
    cc20_pkg::t_word       r_counter;
    cc20_pkg::t_word       r_nonce_live;
    logic [5:0]            r_pos;
    cc20_pkg::t_word       r_work [16];
    cc20_pkg::t_word       n_work [16];
    cc20_pkg::t_word       w_init [16];
    logic [7:0]            r_byte;
    logic                  r_eoc;
    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic                  r_out_last;
    cc20_pkg::t_word       w_ks_word;
    logic [7:0]            w_ks_byte;

    // Block input state
    always_comb begin
        w_init[0] = cc20_pkg::SIGMA0;
        w_init[1] = cc20_pkg::SIGMA1;
        w_init[2] = cc20_pkg::SIGMA2;
        w_init[3] = cc20_pkg::SIGMA3;
        for (int i = 0; i < 4; i++) begin
            w_init[4 + 2*i] = r_key[i][31:0];
            w_init[5 + 2*i] = r_key[i][63:32];
        end
        w_init[12] = r_counter;
        w_init[13] = r_nonce_live;
        w_init[14] = r_nonce_lo[63:32];
        w_init[15] = r_nonce_hi;
    end

    // Four lanes, each half a quarter round; diagonal rounds rotate lane indices
    always_comb begin
        logic [3:0]    v_b;
        logic [3:0]    v_c;
        logic [3:0]    v_d;
        cc20_pkg::t_quad v_q;
        n_work = r_work;
        for (int i = 0; i < 4; i++) begin
            v_b = i_cmd.diag ? {2'b01, 2'(i + 1)} : {2'b01, 2'(i)};
            v_c = i_cmd.diag ? {2'b10, 2'(i + 2)} : {2'b10, 2'(i)};
            v_d = i_cmd.diag ? {2'b11, 2'(i + 3)} : {2'b11, 2'(i)};
            v_q = cc20_pkg::qr_half(r_work[i], r_work[v_b], r_work[v_c],
                                    r_work[v_d], i_cmd.odd_half);
            n_work[i]   = v_q.a;
            n_work[v_b] = v_q.b;
            n_work[v_c] = v_q.c;
            n_work[v_d] = v_q.d;
        end
    end

    assign w_ks_word = r_work[r_pos[5:2]];
    assign w_ks_byte = w_ks_word[{r_pos[1:0], 3'b000} +: 8];

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_block) begin
            r_work <= w_init;
        end else if (i_cmd.round_step) begin
            r_work <= n_work;
        end else if (i_cmd.final_add) begin
            for (int i = 0; i < 16; i++) begin
                r_work[i] <= r_work[i] + w_init[i];
            end
        end
        if (i_cmd.load_item) begin
            r_byte <= i_data_byte;
            r_eoc  <= i_end_of_call;
        end
        if (i_cmd.emit) begin
            r_out_byte <= r_byte ^ w_ks_byte;
            r_out_last <= r_eoc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_key[i] <= '0;
            end
            r_nonce_lo   <= '0;
            r_nonce_hi   <= '0;
            r_counter    <= '0;
            r_nonce_live <= '0;
            r_pos        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    cc20_pkg::REG_KEY_01:   r_key[0]   <= i_cfg_data;
                    cc20_pkg::REG_KEY_23:   r_key[1]   <= i_cfg_data;
                    cc20_pkg::REG_KEY_45:   r_key[2]   <= i_cfg_data;
                    cc20_pkg::REG_KEY_67:   r_key[3]   <= i_cfg_data;
                    cc20_pkg::REG_NONCE_07: r_nonce_lo <= i_cfg_data;
                    cc20_pkg::REG_NONCE_8B: r_nonce_hi <= i_cfg_data[31:0];
                    default: begin
                        // drop writes to unused indexes
                    end
                endcase
            end
            if (i_cmd.restart) begin
                r_counter    <= '0;
                r_nonce_live <= r_nonce_lo[31:0];
                r_pos        <= '0;
            end else if (i_cmd.final_add) begin
                // counter wrap carries into the live nonce word
                r_counter <= r_counter + 1'b1;
                if (r_counter == '1) begin
                    r_nonce_live <= r_nonce_live + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_pos <= r_eoc ? 6'd0 : r_pos + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.pos_zero = (r_pos == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_byte        = r_out_byte;
    assign o_last_of_call    = r_out_last;

endmodule

/* rtl/chacha20_stream_cipher_core.sv */
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_core
// ChaCha20 byte stream cipher with a 32-bit block counter carried into the
// first nonce word; one byte in, one byte out.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    i_kind, i_data_byte, i_end_of_call
//  output    out        o_out_valid / i_out_ready  o_out_byte, o_last_of_call
//  config    in         i_cfg_we                   i_cfg_addr, i_cfg_data
//
//  A data word within a keystream block is accepted, then emitted.
//  A data word at keystream position 0 first runs a new block: the shared round unit
//  does half a quarter round on all four lanes per cycle, 40 steps for 20
//  rounds, then the final add, before it is emitted. A restart word is taken in idle.
//  Reset is synchronous; keystream storage is not cleared. A stalled output
//  holds the result register and the core waits in the emit step.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_kind,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_end_of_call,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_out_byte,
    output logic                            o_last_of_call,
    input  logic                            i_cfg_we,
    input  logic [cc20_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [cc20_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    cc20_pkg::t_cmd    w_cmd;
    cc20_pkg::t_status w_status;

    cc20_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_kind),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    cc20_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_data_byte    (i_data_byte),
        .i_end_of_call  (i_end_of_call),
        .i_out_ready    (i_out_ready),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_last_of_call (o_last_of_call)
    );

endmodule

/* dv/chacha20_stream_cipher_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_core_tb
// Self-checking bench for the ChaCha20 byte stream core. A queue-fed driver
// pushes data and restart words under random gaps and a monitor scores every
// output byte against a bit-true keystream predictor. Key and nonce change
// between phases while the core is idle.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_core_tb;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       eoc;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_cipher_out;

    localparam logic [cc20_pkg::CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [cc20_pkg::CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

    localparam cc20_pkg::t_word EXPAND_0 = 32'h6170_7865;
    localparam cc20_pkg::t_word EXPAND_1 = 32'h3320_646e;
    localparam cc20_pkg::t_word EXPAND_2 = 32'h7962_2d32;
    localparam cc20_pkg::t_word EXPAND_3 = 32'h6b20_6574;

    localparam int NUM_PHASES   = 8;
    localparam int PHASE_WORDS  = 90;
    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 1000;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    logic                            in_kind   = 1'b0;
    logic [7:0]                      in_data   = 8'd0;
    logic                            in_eoc    = 1'b0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [7:0]                      out_byte;
    logic                            out_last;
    logic                            cfg_we    = 1'b0;
    logic [cc20_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [cc20_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor state
    logic [63:0]     cfg_regs [6];
    cc20_pkg::t_word mix [16];
    logic [7:0]      ks_bytes [64];
    cc20_pkg::t_word blk_ctr;
    cc20_pkg::t_word nonce_live;
    logic [5:0]      ks_pos;

    t_in_word    pending_words [$];
    t_cipher_out expected_bytes [$];
    t_in_word    cur_word = '0;
    bit          word_on_bus = 1'b0;
    bit          gap_done = 1'b0;
    int          send_gap = 0;
    int          sink_gap = 0;
    int          send_idle_pct = 0;
    int          sink_idle_pct = 0;
    int          idle_cycles = 0;
    bit          progress;

    int          mismatches = 0;
    int          results_checked = 0;
    int          data_words = 0;
    int          restarts_seen = 0;
    int          blocks_made = 0;

    chacha20_stream_cipher_core uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_kind         (in_kind),
        .i_data_byte    (in_data),
        .i_end_of_call  (in_eoc),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_out_byte     (out_byte),
        .o_last_of_call (out_last),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic cc20_pkg::t_word rol(cc20_pkg::t_word v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void mix_quarter(int a, int b, int c, int d);
        mix[a] = mix[a] + mix[b]; mix[d] = rol(mix[d] ^ mix[a], 16);
        mix[c] = mix[c] + mix[d]; mix[b] = rol(mix[b] ^ mix[c], 12);
        mix[a] = mix[a] + mix[b]; mix[d] = rol(mix[d] ^ mix[a], 8);
        mix[c] = mix[c] + mix[d]; mix[b] = rol(mix[b] ^ mix[c], 7);
    endfunction

    // One 64-byte keystream block from the current counter, then advance it
    function automatic void refill_keystream();
        cc20_pkg::t_word seed [16];
        cc20_pkg::t_word sum;
        int              i;
        seed[0] = EXPAND_0;
        seed[1] = EXPAND_1;
        seed[2] = EXPAND_2;
        seed[3] = EXPAND_3;
        for (i = 0; i < 4; i++) begin
            seed[4 + 2 * i] = cfg_regs[i][31:0];
            seed[5 + 2 * i] = cfg_regs[i][63:32];
        end
        seed[12] = blk_ctr;
        seed[13] = nonce_live;
        seed[14] = cfg_regs[cc20_pkg::REG_NONCE_07][63:32];
        seed[15] = cfg_regs[cc20_pkg::REG_NONCE_8B][31:0];
        for (i = 0; i < 16; i++) mix[i] = seed[i];
        for (i = 0; i < 10; i++) begin
            mix_quarter(0, 4, 8, 12);
            mix_quarter(1, 5, 9, 13);
            mix_quarter(2, 6, 10, 14);
            mix_quarter(3, 7, 11, 15);
            mix_quarter(0, 5, 10, 15);
            mix_quarter(1, 6, 11, 12);
            mix_quarter(2, 7, 8, 13);
            mix_quarter(3, 4, 9, 14);
        end
        for (i = 0; i < 16; i++) begin
            sum = mix[i] + seed[i];
            ks_bytes[4 * i]     = sum[7:0];
            ks_bytes[4 * i + 1] = sum[15:8];
            ks_bytes[4 * i + 2] = sum[23:16];
            ks_bytes[4 * i + 3] = sum[31:24];
        end
        // counter wrap carries into the live nonce word
        blk_ctr = blk_ctr + 32'd1;
        if (blk_ctr == 32'd0) nonce_live = nonce_live + 32'd1;
        blocks_made++;
    endfunction

    function automatic void predict_cipher_word(t_in_word w);
        t_cipher_out res;
        if (w.kind == cc20_pkg::KIND_RESTART) begin
            blk_ctr    = '0;
            nonce_live = cfg_regs[cc20_pkg::REG_NONCE_07][31:0];
            ks_pos     = '0;
            restarts_seen++;
            return;
        end
        if (ks_pos == 6'd0) refill_keystream();
        res.out_byte = w.data ^ ks_bytes[ks_pos];
        res.last     = w.eoc;
        // end of call drops the rest of the block
        ks_pos = w.eoc ? 6'd0 : ks_pos + 6'd1;
        expected_bytes.push_back(res);
        data_words++;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        mismatches++;
        $display("mismatch at result %0d: %s got %h expected %h",
                 results_checked, what, got, want);
    endtask

    // Driver: present one word at a time, hold it until taken
    always @(negedge clk) begin
        if (!word_on_bus) begin
            if (send_gap != 0) begin
                send_gap--;
            end else if (pending_words.size() != 0) begin
                if (!gap_done && $urandom_range(0, 99) < send_idle_pct) begin
                    send_gap = $urandom_range(1, 19) - 1;
                    gap_done = 1'b1;
                end else begin
                    cur_word    = pending_words.pop_front();
                    word_on_bus = 1'b1;
                    gap_done    = 1'b0;
                end
            end
        end
        in_valid <= word_on_bus;
        in_kind  <= cur_word.kind;
        in_data  <= cur_word.data;
        in_eoc   <= cur_word.eoc;
    end

    // Receiver: random stall bursts on the result side
    always @(negedge clk) begin
        if (sink_gap != 0) begin
            sink_gap--;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < sink_idle_pct) begin
            sink_gap = $urandom_range(1, 19) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: predict on input accept, score on output accept, watchdog
    always @(posedge clk) begin
        t_cipher_out want;
        if (rst_n) begin
            progress = cfg_we;
            if (in_valid && in_ready) begin
                predict_cipher_word('{in_kind, in_data, in_eoc});
                word_on_bus = 1'b0;
                progress    = 1'b1;
            end
            if (out_valid && out_ready) begin
                progress = 1'b1;
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected word, byte", out_byte, 8'h00);
                end else begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.out_byte)
                        report_mismatch("out_byte", out_byte, want.out_byte);
                    if (out_last !== want.last)
                        report_mismatch("last_of_call", {7'd0, out_last}, {7'd0, want.last});
                end
                results_checked++;
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         idle_cycles, expected_bytes.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [cc20_pkg::CFG_ADDR_W-1:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        if (idx == cc20_pkg::REG_NONCE_8B)
            cfg_regs[idx] = {32'd0, val[31:0]};
        else if (idx < cc20_pkg::REG_NONCE_8B)
            cfg_regs[idx] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until the bus, the queue and the scoreboard are empty, then settle
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_words.size() != 0 || word_on_bus || expected_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic queue_word(logic kind, logic [7:0] data, logic eoc);
        pending_words.push_back('{kind, data, eoc});
    endtask

    task automatic queue_restart();
        queue_word(cc20_pkg::KIND_RESTART, 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
    endtask

    task automatic load_phase_config(int ph);
        int r;
        case (ph)
            0: for (r = 0; r <= cc20_pkg::REG_NONCE_8B; r++) write_reg(r[2:0], '1);
            1: for (r = 0; r <= cc20_pkg::REG_NONCE_8B; r++) write_reg(r[2:0], '0);
            2: begin
                // nonce only: the live word must stay until the next restart
                write_reg(cc20_pkg::REG_NONCE_07, {$urandom, $urandom});
                write_reg(cc20_pkg::REG_NONCE_8B, {$urandom, $urandom});
            end
            default: begin
                for (r = 0; r <= cc20_pkg::REG_NONCE_8B; r++)
                    write_reg(r[2:0], {$urandom, $urandom});
                if (ph == 3) begin
                    write_reg(REG_SPARE_6, {$urandom, $urandom});
                    write_reg(REG_SPARE_7, '1);
                end
            end
        endcase
    endtask

    // Message calls of random length, with some restarts and open calls mixed in
    task automatic queue_calls(int n_data, bit lead_restart, bit mid_restart);
        int queued;
        int calls;
        int len;
        int k;
        bit open_call;
        queued = 0;
        calls  = 0;
        if (lead_restart)
            queue_restart();
        while (queued < n_data) begin
            if (calls == 1 && mid_restart)
                queue_restart();
            else if ($urandom_range(0, 11) == 0)
                queue_restart();
            if (calls == 0 || $urandom_range(0, 5) == 0)
                len = $urandom_range(65, 150);
            else
                len = $urandom_range(1, 40);
            open_call = ($urandom_range(0, 9) == 0);
            for (k = 0; k < len; k++)
                queue_word(cc20_pkg::KIND_DATA, 8'($urandom_range(0, 255)),
                           (k == len - 1) && !open_call);
            queued += len;
            calls++;
        end
    endtask

    initial begin
        int ph;
        for (ph = 0; ph < 6; ph++) cfg_regs[ph] = '0;
        blk_ctr    = '0;
        nonce_live = '0;
        ks_pos     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset key and nonce: byte extremes, single-byte calls, restarts
        send_idle_pct = 30;
        sink_idle_pct = 10;
        queue_word(cc20_pkg::KIND_DATA,    8'h00, 1'b0);
        queue_word(cc20_pkg::KIND_DATA,    8'hFF, 1'b0);
        queue_word(cc20_pkg::KIND_DATA,    8'h80, 1'b1);
        queue_word(cc20_pkg::KIND_DATA,    8'h01, 1'b1);
        queue_word(cc20_pkg::KIND_RESTART, 8'hFF, 1'b1);
        queue_word(cc20_pkg::KIND_DATA,    8'h7F, 1'b0);
        queue_word(cc20_pkg::KIND_DATA,    8'hAA, 1'b0);
        queue_word(cc20_pkg::KIND_RESTART, 8'h00, 1'b0);
        queue_word(cc20_pkg::KIND_RESTART, 8'h55, 1'b1);
        queue_word(cc20_pkg::KIND_DATA,    8'hFF, 1'b1);
        queue_word(cc20_pkg::KIND_DATA,    8'h00, 1'b0);
        queue_word(cc20_pkg::KIND_DATA,    8'h5A, 1'b1);
        wait_drained();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 4 || ph == NUM_PHASES - 1) begin
                send_idle_pct = 0;
                sink_idle_pct = 0;
            end else if (ph == 5) begin
                send_idle_pct = 60;
                sink_idle_pct = 25;
            end else begin
                send_idle_pct = 20;
                sink_idle_pct = 8;
            end
            load_phase_config(ph);
            queue_calls(PHASE_WORDS, ph != 2, ph == 2);
            wait_drained();
        end

        $display("covered %0d data words, %0d restarts, %0d keystream blocks, %0d phases",
                 data_words, restarts_seen, blocks_made, NUM_PHASES + 1);
        $display("key/nonce extremes, deferred nonce reload, spare indexes, %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
